### sv/rwnh_pkg.sv
`default_nettype none
package rwnh_pkg;

  // Default coordinate width, Q16.8 two's complement.
  localparam int COORD_BITS_DEF = 24;

  // Distance and range register width.
  localparam int DIST_W = 16;

  // View distance after reset.
  localparam logic [DIST_W-1:0] MAX_RANGE_RESET = 16'd512;

  // Input item kinds.
  localparam logic KIND_RAY  = 1'b0;
  localparam logic KIND_WALL = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_TEST,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } seq_state_t;

endpackage
`default_nettype wire

### sv/ray_wall_nearest_hit.sv
`default_nettype none
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     kind, a_x, a_y, b_x, b_y, last
// out      output     out_valid / out_ready   behind_distance, ahead_distance
// cfg      input      cfg_we (no wait)        cfg_wdata = max_range
//
// A ray item is taken in the idle state and leaves the block ready again.
// A wall item keeps in_ready low while it passes the shared multiplier, the sign and
// hit tests, the restoring divider (saturation check, then sixteen quotient bits), one
// update and one emit. A parallel wall goes from the sign test straight to the emit, a
// miss from the hit test straight to the emit. Reset is synchronous.
// A last wall waits in its final state while an earlier result is still held.
module ray_wall_nearest_hit #(
  parameter int COORD_BITS = rwnh_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire  signed [COORD_BITS-1:0] in_a_x,
  input  wire  signed [COORD_BITS-1:0] in_a_y,
  input  wire  signed [COORD_BITS-1:0] in_b_x,
  input  wire  signed [COORD_BITS-1:0] in_b_y,
  input  wire                          in_last,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [rwnh_pkg::DIST_W-1:0]  out_behind_distance,
  output logic [rwnh_pkg::DIST_W-1:0]  out_ahead_distance,
  input  wire                          cfg_we,
  input  wire  [rwnh_pkg::DIST_W-1:0]  cfg_wdata
);
  import rwnh_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int OP_W   = CB + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int PW     = PROD_W + 1;
  localparam int MUL_STEPS = 6;

  seq_state_t state_r, state_nxt;

  logic [DIST_W-1:0]   max_range_r;
  logic signed [CB-1:0] org_x_r, org_y_r, dir_x_r, dir_y_r;
  logic [DIST_W-1:0]   pos_r, neg_r;

  logic signed [OP_W-1:0] dx_r, dy_r, wrx_r, wry_r;
  logic                   last_r;
  logic [2:0]             mcnt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PW-1:0]     den_r, nu_r, nt_r;
  logic                     tneg_r;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]     prod_ext;
  logic [2:0]               acc_sel;
  logic                     accept, out_free;
  logic                     den_zero, miss;
  logic                     div_start, div_done;
  logic [PW-1:0]            div_num;
  logic [DIST_W-1:0]        div_q;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r <= MAX_RANGE_RESET;
    end else if (cfg_we) begin
      max_range_r <= cfg_wdata;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (mcnt_r)
      3'd0: begin mul_a = {dir_x_r[CB-1], dir_x_r}; mul_b = wry_r; end
      3'd1: begin mul_a = {dir_y_r[CB-1], dir_y_r}; mul_b = wrx_r; end
      3'd2: begin mul_a = dx_r; mul_b = {dir_y_r[CB-1], dir_y_r}; end
      3'd3: begin mul_a = dy_r; mul_b = {dir_x_r[CB-1], dir_x_r}; end
      3'd4: begin mul_a = dx_r; mul_b = wry_r; end
      3'd5: begin mul_a = dy_r; mul_b = wrx_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_ext = {prod_r[PROD_W-1], prod_r};
  assign acc_sel  = mcnt_r - 3'd1;
  assign den_zero = (den_r == '0);
  // After normalizing, den is positive: a hit needs 0 <= nu <= den.
  assign miss     = nu_r[PW-1] || (nu_r > den_r);
  assign div_num  = nt_r[PW-1] ? PW'(-nt_r) : PW'(nt_r);
  assign div_start = (state_r == ST_TEST) && !miss;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_WALL) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mcnt_r == 3'(MUL_STEPS)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: state_nxt = den_zero ? ST_EMIT : ST_TEST;
      ST_TEST: state_nxt = miss ? ST_EMIT : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!last_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ray state and the two bounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      pos_r   <= MAX_RANGE_RESET;
      neg_r   <= MAX_RANGE_RESET;
    end else if (accept && in_kind == KIND_RAY) begin
      org_x_r <= in_a_x;
      org_y_r <= in_a_y;
      dir_x_r <= in_b_x;
      dir_y_r <= in_b_y;
      pos_r   <= max_range_r;
      neg_r   <= max_range_r;
    end else if (state_r == ST_UPD && div_q != '0) begin
      // A quotient of zero is ignored; saturation never beats a bound.
      if (!tneg_r && div_q < pos_r) begin
        pos_r <= div_q;
      end
      if (tneg_r && div_q < neg_r) begin
        neg_r <= div_q;
      end
    end
  end

  // Wall capture, relative to the ray origin.
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_WALL) begin
      dx_r   <= OP_W'(in_a_x) - OP_W'(org_x_r);
      dy_r   <= OP_W'(in_a_y) - OP_W'(org_y_r);
      wrx_r  <= OP_W'(in_b_x);
      wry_r  <= OP_W'(in_b_y);
      last_r <= in_last;
    end
  end

  // Multiply step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (state_r == ST_MUL) begin
      mcnt_r <= mcnt_r + 3'd1;
    end else begin
      mcnt_r <= '0;
    end
  end

  // Shared multiplier; each registered product is accumulated in the following cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
      if (mcnt_r != '0) begin
        unique case (acc_sel)
          3'd0: den_r <= prod_ext;
          3'd1: den_r <= den_r - prod_ext;
          3'd2: nu_r  <= prod_ext;
          3'd3: nu_r  <= nu_r - prod_ext;
          3'd4: nt_r  <= prod_ext;
          3'd5: nt_r  <= nt_r - prod_ext;
          default: ;
        endcase
      end
    end else if (state_r == ST_NORM && den_r[PW-1]) begin
      // Make the denominator positive.
      den_r <= -den_r;
      nu_r  <= -nu_r;
      nt_r  <= -nt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TEST) begin
      tneg_r <= nt_r[PW-1];
    end
  end

  rwnh_divider #(
    .PW(PW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (PW'(den_r)),
    .done  (div_done),
    .quot  (div_q)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_EMIT && last_r && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && last_r && out_free) begin
      out_behind_distance <= neg_r;
      out_ahead_distance  <= pos_r;
    end
  end

endmodule
`default_nettype wire

### sv/rwnh_divider.sv
`default_nettype none
module rwnh_divider #(
  parameter int PW = 2 * rwnh_pkg::COORD_BITS_DEF + 3
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [PW-1:0]               num,
  input  wire  [PW-1:0]               den,
  output logic                        done,
  output logic [rwnh_pkg::DIST_W-1:0] quot
);
  import rwnh_pkg::*;

  localparam int CNT_W = $clog2(DIST_W + 1);
  localparam int SH_W  = PW + DIST_W;
  localparam logic [CNT_W-1:0] SAT_STEP = CNT_W'(DIST_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PW-1:0]     rem_r;
  logic [SH_W-1:0]   dsh_r;
  logic [DIST_W-1:0] q_r;
  logic              ge;

  // One restoring step a cycle: compare the remainder against the shifted divisor.
  assign ge = {{DIST_W{1'b0}}, rem_r} >= dsh_r;

  // The first step only checks for saturation; then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SAT_STEP;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if ((cnt_r == SAT_STEP && ge) || cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {DIST_W{1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      if (cnt_r == SAT_STEP) begin
        if (ge) begin
          q_r <= '1;
        end
      end else begin
        q_r <= {q_r[DIST_W-2:0], ge};
        if (ge) begin
          rem_r <= rem_r - dsh_r[PW-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

### sv/rwnh_checker.sv
`default_nettype none
module rwnh_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         in_kind,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [rwnh_pkg::DIST_W-1:0]  out_behind_distance,
  input wire [rwnh_pkg::DIST_W-1:0]  out_ahead_distance
);
  import rwnh_pkg::*;

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A held result keeps its distances until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_behind_distance)
      && $stable(out_ahead_distance))
    else $error("result changed while stalled");

  // A wall item occupies the block for the next cycle.
  a_wall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_WALL |=> !in_ready)
    else $error("ready right after a wall item");

  // A ray item never produces a result.
  a_ray_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_RAY |=> !$rose(out_valid))
    else $error("result after a ray item");

endmodule

bind ray_wall_nearest_hit rwnh_checker u_rwnh_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_kind             (in_kind),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_behind_distance (out_behind_distance),
  .out_ahead_distance  (out_ahead_distance)
);
`default_nettype wire

### tb/tb_ray_wall_nearest_hit.sv
`timescale 1ns / 100ps

module tb_ray_wall_nearest_hit;
  import rwnh_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  // Cycles a wall item may still be in flight after the last result has left.
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct {
    logic   kind;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    logic   last;
  } item_t;

  typedef struct {
    dist_t behind;
    dist_t ahead;
  } dist_pair_t;

  typedef struct {
    item_t it;
    bit    typed;
    dist_t behind;
    dist_t ahead;
  } row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_kind = 1'b0;
  coord_t in_a_x = '0;
  coord_t in_a_y = '0;
  coord_t in_b_x = '0;
  coord_t in_b_y = '0;
  logic   in_last = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  dist_t  out_behind_distance;
  dist_t  out_ahead_distance;
  logic   cfg_we = 1'b0;
  dist_t  cfg_wdata = '0;

  // Predictor state: the current ray, both bounds and the view distance.
  longint     ray_ox, ray_oy, ray_dx, ray_dy;
  int         bound_ahead, bound_behind;
  dist_t      range_reg;
  dist_pair_t pending_dists[$];
  row_t       directed_rows[$];
  int         error_count = 0;
  bit         send_calm = 1'b0;
  bit         take_calm = 1'b0;

  ray_wall_nearest_hit #(
    .COORD_BITS(CW)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_a_x             (in_a_x),
    .in_a_y             (in_a_y),
    .in_b_x             (in_b_x),
    .in_b_y             (in_b_y),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_behind_distance(out_behind_distance),
    .out_ahead_distance (out_ahead_distance),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle cycles before the next item; a side now and then runs flat out for a stretch.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  // Style 0 spans +/- span, style 1 the full range, style 2 the corner values.
  function automatic coord_t rand_coord(input int style, input int span);
    int v;
    if (style == 1) begin
      return coord_t'($urandom);
    end
    if (style == 2) begin
      case ($urandom_range(0, 4))
        0: return {1'b1, {(CW-1){1'b0}}};
        1: return {1'b0, {(CW-1){1'b1}}};
        2: return '0;
        3: return '1;
        default: return coord_t'(1);
      endcase
    end
    v = int'($urandom_range(0, 2 * span)) - span;
    return coord_t'(v);
  endfunction

  // Updates the ray state for one item; returns 1 with the distances on a last wall.
  function automatic bit track_hits(input item_t it, output dist_pair_t res);
    longint dx, dy, den, nu, nt, mag, quo;
    bit     tneg;
    res.behind = '0;
    res.ahead = '0;
    if (it.kind == KIND_RAY) begin
      ray_ox = longint'(it.ax);
      ray_oy = longint'(it.ay);
      ray_dx = longint'(it.bx);
      ray_dy = longint'(it.by);
      bound_ahead = int'(range_reg);
      bound_behind = int'(range_reg);
      return 1'b0;
    end
    dx = longint'(it.ax) - ray_ox;
    dy = longint'(it.ay) - ray_oy;
    den = ray_dx * longint'(it.by) - ray_dy * longint'(it.bx);
    nu = dx * ray_dy - dy * ray_dx;
    nt = dx * longint'(it.by) - dy * longint'(it.bx);
    // A parallel wall never hits; otherwise the wall parameter must lie in [0,1].
    if (den != 0) begin
      if (den < 0) begin
        den = -den;
        nu = -nu;
        nt = -nt;
      end
      if (nu >= 0 && nu <= den) begin
        tneg = (nt < 0);
        mag = tneg ? -nt : nt;
        quo = mag / den;
        if (quo > 65535) begin
          quo = 65535;
        end
        // A ray parameter that truncates to zero leaves both bounds alone.
        if (quo != 0) begin
          if (!tneg) begin
            if (quo < bound_ahead) begin
              bound_ahead = int'(quo);
            end
          end else begin
            if (quo < bound_behind) begin
              bound_behind = int'(quo);
            end
          end
        end
      end
    end
    if (!it.last) begin
      return 1'b0;
    end
    res.behind = dist_t'(bound_behind);
    res.ahead = dist_t'(bound_ahead);
    return 1'b1;
  endfunction

  // Offers one item, waits for its acceptance and files what it should produce.
  task automatic send(input item_t it, input bit typed, input dist_t fix_behind,
                      input dist_t fix_ahead);
    int         gap;
    dist_pair_t res;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_a_x <= it.ax;
    in_a_y <= it.ay;
    in_b_x <= it.bx;
    in_b_y <= it.by;
    in_last <= it.last;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (track_hits(it, res)) begin
      if (typed) begin
        res.behind = fix_behind;
        res.ahead = fix_ahead;
      end
      pending_dists.push_back(res);
    end
  endtask

  // Holds the sender until every pending result is out and the block has settled.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dists.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(input dist_t value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    range_reg = value;
  endtask

  function automatic void add_row(input logic kind, input int ax, input int ay,
                                  input int bx, input int by, input logic last,
                                  input bit typed, input int behind, input int ahead);
    row_t r;
    r.it.kind = kind;
    r.it.ax = coord_t'(ax);
    r.it.ay = coord_t'(ay);
    r.it.bx = coord_t'(bx);
    r.it.by = coord_t'(by);
    r.it.last = last;
    r.typed = typed;
    r.behind = dist_t'(behind);
    r.ahead = dist_t'(ahead);
    directed_rows.push_back(r);
  endfunction

  // Mostly whole rays with a few walls each, plus stray items and unterminated rays.
  task automatic run_random(input int budget);
    int    sent;
    int    walls;
    int    style;
    item_t it;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        style = ($urandom_range(0, 9) < 7) ? 0 : int'($urandom_range(1, 2));
        it.kind = KIND_RAY;
        it.ax = rand_coord(style, 16384);
        it.ay = rand_coord(style, 16384);
        it.bx = rand_coord(style, 1024);
        it.by = rand_coord(style, 1024);
        it.last = ($urandom_range(0, 7) == 0);
        send(it, 1'b0, '0, '0);
        walls = $urandom_range(1, 6);
        for (int i = 0; i < walls; i++) begin
          it.kind = KIND_WALL;
          it.ax = rand_coord(style, 16384);
          it.ay = rand_coord(style, 16384);
          it.bx = rand_coord(style, 16384);
          it.by = rand_coord(style, 16384);
          it.last = (i == walls - 1) && ($urandom_range(0, 7) != 0);
          send(it, 1'b0, '0, '0);
        end
        sent += walls + 1;
      end else begin
        it.kind = logic'($urandom_range(0, 1));
        it.ax = rand_coord(1, 0);
        it.ay = rand_coord(1, 0);
        it.bx = rand_coord(1, 0);
        it.by = rand_coord(1, 0);
        it.last = logic'($urandom_range(0, 1));
        send(it, 1'b0, '0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random stalls between results.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Every accepted result is matched against the oldest pending one.
  always @(posedge clk) begin : check_results
    dist_pair_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_dists.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected result: behind %0d ahead %0d",
                   out_behind_distance, out_ahead_distance);
        end
        error_count++;
      end else begin
        want = pending_dists.pop_front();
        if (out_behind_distance !== want.behind || out_ahead_distance !== want.ahead) begin
          if (error_count < 10) begin
            $display("mismatch: behind %0d (want %0d) ahead %0d (want %0d)",
                     out_behind_distance, want.behind, out_ahead_distance, want.ahead);
          end
          error_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    range_reg = MAX_RANGE_RESET;
    ray_ox = 0;
    ray_oy = 0;
    ray_dx = 0;
    ray_dy = 0;
    bound_ahead = int'(MAX_RANGE_RESET);
    bound_behind = int'(MAX_RANGE_RESET);

    // A wall before any ray sees a zero direction and is parallel.
    add_row(KIND_WALL, 8388607, -8388608, -8388608, 8388607, 1'b1, 1'b1, 512, 512);
    // A last flag on a ray item produces nothing.
    add_row(KIND_RAY, 0, 0, 256, 0, 1'b1, 1'b0, 0, 0);
    // Hits ahead and behind along the x axis.
    add_row(KIND_WALL, 2560, -256, 0, 512, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, -1280, -256, 0, 512, 1'b1, 1'b0, 0, 0);
    // Walls after the last one keep tightening the same bounds.
    add_row(KIND_WALL, 0, 256, 512, 0, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 768, 0, 0, 256, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 512, -256, 0, 256, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 256, -257, 0, 256, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 100, -256, 0, 512, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, -100, -256, 0, 512, 1'b1, 1'b0, 0, 0);
    // A huge ray parameter saturates and cannot tighten a bound.
    add_row(KIND_RAY, -8388608, 0, 1, 0, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 8388607, -1, 0, 2, 1'b1, 1'b1, 512, 512);
    // A wall along the ray is parallel.
    add_row(KIND_RAY, 0, 0, 0, 256, 1'b1, 1'b0, 0, 0);
    add_row(KIND_WALL, 0, 0, 0, 256, 1'b1, 1'b1, 512, 512);
    // Negative denominator with a hit.
    add_row(KIND_RAY, 0, 0, -256, -256, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, -512, -1024, 0, 2048, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, -512, 0, 0, -1024, 1'b1, 1'b0, 0, 0);
    // Corner values in every coordinate.
    add_row(KIND_RAY, 8388607, -8388608, -8388608, 8388607, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, -8388608, 8388607, 8388607, -8388608, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 0, 0, -1, -1, 1'b1, 1'b0, 0, 0);
    add_row(KIND_RAY, -1, -1, 8388607, 8388607, 1'b0, 1'b0, 0, 0);
    add_row(KIND_WALL, 8388607, -8388608, -8388608, 8388607, 1'b1, 1'b0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].behind,
           directed_rows[i].ahead);
    end
    drain();

    // Random phases under several view distances, the extremes among them.
    write_range(16'd65535);
    run_random(110);
    drain();
    write_range(16'd1);
    run_random(40);
    drain();
    write_range(16'd0);
    run_random(40);
    drain();
    write_range(dist_t'($urandom_range(2, 65534)));
    run_random(110);
    drain();
    write_range(dist_t'($urandom_range(16, 200)));
    run_random(100);
    drain();

    if (error_count == 0 && pending_dists.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
